// File: rtl/dcfe_pkg.sv
// ----------------------------------------------------------------------------
// DMA copy/fill engine package
// Shared constants, codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package dcfe_pkg;

  // Line, ring and beat sizes are powers of two.
  localparam int LINE_BYTES   = 64;
  localparam int BUFFER_BYTES = 4096;
  localparam int BEAT_BYTES   = 8;

  localparam logic [2:0] REQ_START_COPY = 3'd0;
  localparam logic [2:0] REQ_START_FILL = 3'd1;
  localparam logic [2:0] REQ_TICK       = 3'd2;
  localparam logic [2:0] REQ_READ_RESP  = 3'd3;
  localparam logic [2:0] REQ_WRITE_RESP = 3'd4;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_BEAT   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic PORT_HOST   = 1'b0;
  localparam logic PORT_DEVICE = 1'b1;

  localparam logic [1:0] DIR_H2D = 2'd0;
  localparam logic [1:0] DIR_D2H = 2'd1;

  localparam logic [2:0] CFG_SRC_ADDR  = 3'd0;
  localparam logic [2:0] CFG_DST_ADDR  = 3'd1;
  localparam logic [2:0] CFG_LENGTH    = 3'd2;
  localparam logic [2:0] CFG_FILL      = 3'd3;
  localparam logic [2:0] CFG_DIRECTION = 3'd4;
  localparam logic [2:0] CFG_LIMIT     = 3'd5;

  typedef struct packed {
    logic cap_in;
    logic start;
    logic clr_step;
    logic rd_emit;
    logic wr_begin;
    logic byte_rd;
    logic byte_cap;
    logic beat_emit;
    logic rsp_byte;
    logic rsp_end;
    logic walk_step;
    logic walk_end;
    logic ack;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       busy;
    logic       fill;
    logic       start_ok;
    logic       tick_go;
    logic       rd_ok;
    logic       wr_ok;
    logic       clr_last;
    logic       byte_last;
    logic       beat_last;
    logic       rsp_more;
    logic       walk_more;
    logic       map_hit;
    logic       ack_done;
  } stat_t;

endpackage

// File: rtl/dma_copy_fill_engine_unit.sv
// ----------------------------------------------------------------------------
// DMA copy/fill engine
// Copies or fills a programmed byte range through line-aligned requests.
// ----------------------------------------------------------------------------
// Each transaction is handled to completion before the next is taken. A start
// clears the arrival map one entry per cycle. A tick may emit a read request
// and the beats of one write; copied bytes are read through the single ring
// read port. A read response stores its in-range beat bytes one at a time,
// then advances the contiguous read point through the arrival map port. A
// write response counts acknowledged bytes. Every result waits in the output
// register until taken.
module dma_copy_fill_engine_unit #(
  parameter int LINE_BYTES   = dcfe_pkg::LINE_BYTES,
  parameter int BUFFER_BYTES = dcfe_pkg::BUFFER_BYTES,
  parameter int BEAT_BYTES   = dcfe_pkg::BEAT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic        in_read_stalled,
  input  logic        in_write_stalled,
  input  logic [47:0] in_resp_addr,
  input  logic [6:0]  in_resp_bytes,
  input  logic [63:0] in_resp_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_port,
  output logic [47:0] out_req_addr,
  output logic [6:0]  out_req_bytes,
  output logic [63:0] out_beat_data,
  output logic [3:0]  out_beat_bytes,
  output logic        out_last
);

  dcfe_pkg::cmd_t  cmd;
  dcfe_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  dcfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcfe_dp #(
    .LINE_BYTES   (LINE_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES),
    .BEAT_BYTES   (BEAT_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_read_stalled  (in_read_stalled),
    .in_write_stalled (in_write_stalled),
    .in_resp_addr     (in_resp_addr),
    .in_resp_bytes    (in_resp_bytes),
    .in_resp_data     (in_resp_data),
    .out_kind         (out_kind),
    .out_port         (out_port),
    .out_req_addr     (out_req_addr),
    .out_req_bytes    (out_req_bytes),
    .out_beat_data    (out_beat_data),
    .out_beat_bytes   (out_beat_bytes),
    .out_last         (out_last),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// File: rtl/dcfe_ctrl.sv
// ----------------------------------------------------------------------------
// DMA copy/fill engine controller
// Sequences each transaction through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module dcfe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  dcfe_pkg::stat_t stat,
  output dcfe_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CLEAR, S_RD, S_WR, S_BRD, S_BCAP, S_BEMIT,
    S_OUT, S_RSP, S_WALK_RD, S_WALK_CHK, S_ACK
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.req_type) inside
          dcfe_pkg::REQ_START_COPY, dcfe_pkg::REQ_START_FILL: begin
            if (stat.start_ok) begin
              cmd.start = 1'b1;
              state_nxt = S_CLEAR;
            end
          end
          dcfe_pkg::REQ_TICK: begin
            if (stat.tick_go) state_nxt = S_RD;
          end
          dcfe_pkg::REQ_READ_RESP: begin
            if (stat.busy && !stat.fill) state_nxt = S_RSP;
          end
          dcfe_pkg::REQ_WRITE_RESP: begin
            if (stat.busy) state_nxt = S_ACK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_RD: begin
        if (stat.rd_ok) begin
          cmd.rd_emit   = 1'b1;
          out_valid_nxt = 1'b1;
          ret_nxt       = S_WR;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (stat.wr_ok) begin
          cmd.wr_begin = 1'b1;
          state_nxt    = S_BRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BRD: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = S_BCAP;
      end
      S_BCAP: begin
        cmd.byte_cap = 1'b1;
        state_nxt    = stat.byte_last ? S_BEMIT : S_BRD;
      end
      S_BEMIT: begin
        cmd.beat_emit = 1'b1;
        out_valid_nxt = 1'b1;
        ret_nxt       = stat.beat_last ? S_IDLE : S_BRD;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ret_r;
        end
      end
      S_RSP: begin
        if (stat.rsp_more) begin
          cmd.rsp_byte = 1'b1;
        end else begin
          cmd.rsp_end = 1'b1;
          state_nxt   = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (stat.walk_more) begin
          state_nxt = S_WALK_CHK;
        end else begin
          cmd.walk_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WALK_CHK: begin
        if (stat.map_hit) begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_WALK_RD;
        end else begin
          cmd.walk_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ACK: begin
        cmd.ack = 1'b1;
        if (stat.ack_done) begin
          out_valid_nxt = 1'b1;
          ret_nxt       = S_IDLE;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/dcfe_dp.sv
// ----------------------------------------------------------------------------
// DMA copy/fill engine datapath
// Holds the configuration, the transfer state, the data ring, the arrival map
// and the result register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
module dcfe_dp #(
  parameter int LINE_BYTES   = dcfe_pkg::LINE_BYTES,
  parameter int BUFFER_BYTES = dcfe_pkg::BUFFER_BYTES,
  parameter int BEAT_BYTES   = dcfe_pkg::BEAT_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data,
  input  logic [2:0]      in_req_type,
  input  logic            in_read_stalled,
  input  logic            in_write_stalled,
  input  logic [47:0]     in_resp_addr,
  input  logic [6:0]      in_resp_bytes,
  input  logic [63:0]     in_resp_data,
  output logic [1:0]      out_kind,
  output logic            out_port,
  output logic [47:0]     out_req_addr,
  output logic [6:0]      out_req_bytes,
  output logic [63:0]     out_beat_data,
  output logic [3:0]      out_beat_bytes,
  output logic            out_last,
  input  dcfe_pkg::cmd_t  cmd,
  output dcfe_pkg::stat_t stat
);

  localparam int LOW = $clog2(LINE_BYTES);
  localparam int SZW = LOW + 1;
  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int BIW = (BEAT_BYTES > 1) ? $clog2(BEAT_BYTES) : 1;
  localparam int BBW = $clog2(BEAT_BYTES + 1);

  logic [47:0] src_addr_r, dst_addr_r;
  logic [31:0] length_r;
  logic [7:0]  fill_value_r;
  logic [1:0]  direction_r;
  logic [12:0] limit_r;

  logic [2:0]  typ_r;
  logic        rstall_r, wstall_r;
  logic [47:0] raddr_r;
  logic [6:0]  rbytes_r;
  logic [63:0] rdata_r;

  logic        busy_r, fill_r, want_rd_r, want_wr_r, rd_port_r, wr_port_r;
  logic [47:0] next_rd_r, next_wr_r, start_r;
  logic [31:0] rd_rem_r, wr_rem_r, total_r, contig_r, acked_r;

  logic [AW-1:0]  clr_cnt_r;
  logic [SZW-1:0] wsz_r, done_r;
  logic [BIW-1:0] bi_r;
  logic [63:0]    bdata_r;
  logic [3:0]     rsp_i_r;

  logic [1:0]  o_kind_r;
  logic        o_port_r, o_last_r;
  logic [47:0] o_addr_r;
  logic [6:0]  o_bytes_r;
  logic [63:0] o_data_r;
  logic [3:0]  o_bb_r;

  logic [7:0]  ring_mem [BUFFER_BYTES];
  logic        map_mem  [BUFFER_BYTES];
  logic [7:0]  ring_q;
  logic        map_q;
  logic        ring_we, map_we, map_wd;
  logic [AW-1:0] ring_wa, map_wa, ring_ra, map_ra;
  logic [7:0]  ring_wd;

  logic [31:0]    issued, written, ahead;
  logic [SZW-1:0] rd_line, wr_line, rd_sz, wr_sz, left;
  logic [BBW-1:0] bb;
  logic [33:0]    room;
  logic           full, room_ok;
  logic [AW-1:0]  slot_w;
  logic [47:0]    off;
  logic           off_hit;
  logic [3:0]     rsp_n;
  logic [32:0]    acked_sum;
  logic [7:0]     byte_in;

  always_comb begin
    issued  = total_r - rd_rem_r;
    written = total_r - wr_rem_r;
    ahead   = contig_r - written;
    rd_line = SZW'(LINE_BYTES) - {1'b0, next_rd_r[LOW-1:0]};
    wr_line = SZW'(LINE_BYTES) - {1'b0, next_wr_r[LOW-1:0]};
    rd_sz   = (rd_rem_r < 32'(rd_line)) ? rd_rem_r[SZW-1:0] : rd_line;
    wr_sz   = (wr_rem_r < 32'(wr_line)) ? wr_rem_r[SZW-1:0] : wr_line;
    full    = (limit_r != '0) && (ahead > 32'(limit_r));
    room    = {2'b0, issued} + 34'(rd_sz) - {2'b0, written};
    room_ok = !room[33] && (room <= 34'(BUFFER_BYTES));
    left    = wsz_r - done_r;
    bb      = (left > SZW'(BEAT_BYTES)) ? BBW'(BEAT_BYTES) : BBW'(left);
    slot_w  = written[AW-1:0] + AW'(done_r) + AW'(bi_r);
    off     = raddr_r + 48'(rsp_i_r) - start_r;
    off_hit = (off >= 48'(contig_r)) && (off < 48'(issued));
    rsp_n   = (rbytes_r > 7'd8) ? 4'd8 : rbytes_r[3:0];
    acked_sum = {1'b0, acked_r} + 33'(rbytes_r);
    byte_in = fill_r ? fill_value_r : ring_q;
  end

  always_comb begin
    stat.req_type  = typ_r;
    stat.busy      = busy_r;
    stat.fill      = fill_r;
    stat.start_ok  = !busy_r && (length_r != '0);
    stat.tick_go   = busy_r && !(rstall_r && wstall_r);
    stat.rd_ok     = want_rd_r && !rstall_r && !full && (rd_rem_r != '0) && room_ok;
    stat.wr_ok     = want_wr_r && !wstall_r && (written < contig_r) && (wr_rem_r != '0)
                     && ({1'b0, contig_r} >= ({1'b0, written} + 33'(wr_sz)));
    stat.clr_last  = (clr_cnt_r == AW'(BUFFER_BYTES - 1));
    stat.byte_last = ((BBW'(bi_r) + BBW'(1)) == bb);
    stat.beat_last = ((done_r + SZW'(bb)) >= wsz_r);
    stat.rsp_more  = (rsp_i_r < rsp_n);
    stat.walk_more = (contig_r < issued);
    stat.map_hit   = map_q;
    stat.ack_done  = (acked_sum >= {1'b0, total_r});
  end

  always_comb begin
    ring_we = cmd.rsp_byte && off_hit;
    ring_wa = off[AW-1:0];
    ring_wd = rdata_r[{rsp_i_r[2:0], 3'b000} +: 8];
    ring_ra = slot_w;
    map_ra  = contig_r[AW-1:0];
    map_we  = 1'b0;
    map_wa  = clr_cnt_r;
    map_wd  = 1'b0;
    if (cmd.clr_step) begin
      map_we = 1'b1;
    end else if (cmd.rsp_byte) begin
      map_we = off_hit;
      map_wa = off[AW-1:0];
      map_wd = 1'b1;
    end else if (cmd.byte_rd) begin
      map_we = !fill_r;
      map_wa = slot_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_q <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r   <= '0;
      dst_addr_r   <= '0;
      length_r     <= 32'd1;
      fill_value_r <= '0;
      direction_r  <= '0;
      limit_r      <= '0;
      busy_r       <= 1'b0;
      fill_r       <= 1'b0;
      want_rd_r    <= 1'b0;
      want_wr_r    <= 1'b0;
      rd_port_r    <= dcfe_pkg::PORT_HOST;
      wr_port_r    <= dcfe_pkg::PORT_HOST;
      next_rd_r    <= '0;
      next_wr_r    <= '0;
      start_r      <= '0;
      rd_rem_r     <= '0;
      wr_rem_r     <= '0;
      total_r      <= '0;
      contig_r     <= '0;
      acked_r      <= '0;
      clr_cnt_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dcfe_pkg::CFG_SRC_ADDR:  src_addr_r   <= cfg_data;
          dcfe_pkg::CFG_DST_ADDR:  dst_addr_r   <= cfg_data;
          dcfe_pkg::CFG_LENGTH:    length_r     <= cfg_data[31:0];
          dcfe_pkg::CFG_FILL:      fill_value_r <= cfg_data[7:0];
          dcfe_pkg::CFG_DIRECTION: direction_r  <= cfg_data[1:0];
          dcfe_pkg::CFG_LIMIT:     limit_r      <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        busy_r    <= 1'b1;
        total_r   <= length_r;
        wr_rem_r  <= length_r;
        acked_r   <= '0;
        next_wr_r <= dst_addr_r;
        clr_cnt_r <= '0;
        if (typ_r == dcfe_pkg::REQ_START_COPY) begin
          fill_r    <= 1'b0;
          want_rd_r <= 1'b1;
          want_wr_r <= 1'b0;
          next_rd_r <= src_addr_r;
          start_r   <= src_addr_r;
          rd_rem_r  <= length_r;
          contig_r  <= '0;
          rd_port_r <= (direction_r == dcfe_pkg::DIR_H2D) ? dcfe_pkg::PORT_HOST
                                                          : dcfe_pkg::PORT_DEVICE;
          wr_port_r <= (direction_r == dcfe_pkg::DIR_D2H) ? dcfe_pkg::PORT_HOST
                                                          : dcfe_pkg::PORT_DEVICE;
        end else begin
          fill_r    <= 1'b1;
          want_rd_r <= 1'b0;
          want_wr_r <= 1'b1;
          next_rd_r <= '0;
          start_r   <= dst_addr_r;
          rd_rem_r  <= '0;
          contig_r  <= length_r;
          rd_port_r <= dcfe_pkg::PORT_HOST;
          wr_port_r <= dcfe_pkg::PORT_DEVICE;
        end
      end
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.rd_emit) begin
        next_rd_r <= next_rd_r + 48'(rd_sz);
        rd_rem_r  <= rd_rem_r - 32'(rd_sz);
        if (rd_rem_r == 32'(rd_sz)) want_rd_r <= 1'b0;
      end
      if (cmd.beat_emit && stat.beat_last) begin
        next_wr_r <= next_wr_r + 48'(wsz_r);
        wr_rem_r  <= wr_rem_r - 32'(wsz_r);
      end
      if (cmd.rsp_end && (contig_r < total_r)) want_wr_r <= 1'b1;
      if (cmd.walk_step) contig_r <= contig_r + 32'd1;
      if (cmd.walk_end && (contig_r >= total_r)) want_rd_r <= 1'b0;
      if (cmd.ack) begin
        if (stat.ack_done) begin
          busy_r    <= 1'b0;
          want_rd_r <= 1'b0;
          want_wr_r <= 1'b0;
          acked_r   <= total_r;
        end else begin
          acked_r <= acked_sum[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      typ_r    <= in_req_type;
      rstall_r <= in_read_stalled;
      wstall_r <= in_write_stalled;
      raddr_r  <= in_resp_addr;
      rbytes_r <= in_resp_bytes;
      rdata_r  <= in_resp_data;
      rsp_i_r  <= '0;
    end
    if (cmd.rsp_byte) rsp_i_r <= rsp_i_r + 4'd1;
    if (cmd.wr_begin) begin
      wsz_r   <= wr_sz;
      done_r  <= '0;
      bi_r    <= '0;
      bdata_r <= '0;
    end
    if (cmd.byte_cap) begin
      bdata_r[{bi_r, 3'b000} +: 8] <= byte_in;
      if (!stat.byte_last) bi_r <= bi_r + BIW'(1);
    end
    if (cmd.beat_emit) begin
      o_kind_r  <= dcfe_pkg::KIND_BEAT;
      o_port_r  <= wr_port_r;
      o_addr_r  <= next_wr_r + 48'(done_r);
      o_bytes_r <= 7'(wsz_r);
      o_data_r  <= bdata_r;
      o_bb_r    <= 4'(bb);
      o_last_r  <= stat.beat_last;
      done_r    <= done_r + SZW'(bb);
      bi_r      <= '0;
      bdata_r   <= '0;
    end
    if (cmd.rd_emit) begin
      o_kind_r  <= dcfe_pkg::KIND_READ;
      o_port_r  <= rd_port_r;
      o_addr_r  <= next_rd_r;
      o_bytes_r <= 7'(rd_sz);
      o_data_r  <= '0;
      o_bb_r    <= '0;
      o_last_r  <= 1'b0;
    end
    if (cmd.ack) begin
      o_kind_r  <= dcfe_pkg::KIND_FINISH;
      o_port_r  <= dcfe_pkg::PORT_HOST;
      o_addr_r  <= '0;
      o_bytes_r <= '0;
      o_data_r  <= '0;
      o_bb_r    <= '0;
      o_last_r  <= 1'b1;
    end
  end

  assign out_kind       = o_kind_r;
  assign out_port       = o_port_r;
  assign out_req_addr   = o_addr_r;
  assign out_req_bytes  = o_bytes_r;
  assign out_beat_data  = o_data_r;
  assign out_beat_bytes = o_bb_r;
  assign out_last       = o_last_r;

endmodule
